FILE: sv/lat4d_pkg.sv
// Shared codes for the 4D lattice site address unit.
`timescale 1ns / 1ps

package lat4d_pkg;

  typedef enum logic [2:0] {
    FN_IDX_TO_CRD  = 3'd0,
    FN_CRD_TO_IDX  = 3'd1,
    FN_NBR_FWD_IDX = 3'd2,
    FN_NBR_BWD_IDX = 3'd3,
    FN_NBR_FWD_CRD = 3'd4,
    FN_NBR_BWD_CRD = 3'd5,
    FN_EVEN        = 3'd6,
    FN_ODD         = 3'd7
  } func_e;

  localparam logic [2:0] DIR_X = 3'd0;
  localparam logic [2:0] DIR_Y = 3'd1;
  localparam logic [2:0] DIR_Z = 3'd2;
  localparam logic [2:0] DIR_T = 3'd3;

  localparam logic [2:0] CFG_EXTENT_X = 3'd0;
  localparam logic [2:0] CFG_EXTENT_Y = 3'd1;
  localparam logic [2:0] CFG_EXTENT_Z = 3'd2;
  localparam logic [2:0] CFG_EXTENT_T = 3'd3;

  localparam int unsigned CFG_W   = 7;
  localparam int unsigned INDEX_W = 24;
  localparam int unsigned COORD_W = 6;

endpackage

FILE: sv/lattice_4d_site_address_unit_core.sv
// Pipelined address unit for a periodic 4D lattice: index/coordinate
// conversion, neighbours with wraparound and checkerboard site mapping.
//
// Channels: the request channel (in_valid_i / in_stall_o) carries func, index,
// direction and coordinates; the result channel (out_valid_o / out_stall_i)
// returns one result item per request. An item moves when valid is high and
// stall is low. The configuration channel (cfg_valid_i / cfg_ready_o) writes
// the four extent registers; it is always ready.
//
// Throughput is one item per cycle while neither side stalls. After the input
// stage, the index split is a restoring divider taking one quotient bit per
// stage, followed by one neighbour stage, one carry stage and three multiply
// stages for the join.
//
// After reset and after every configuration write the request side stalls
// while the extent products are recomputed. A stall on the result side while
// out_valid_o is high freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps

module lattice_4d_site_address_unit_core
  import lat4d_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           func_i,
  input  logic [INDEX_W-1:0]   site_index_i,
  input  logic [2:0]           direction_i,
  input  logic [COORD_W-1:0]   in_x_i,
  input  logic [COORD_W-1:0]   in_y_i,
  input  logic [COORD_W-1:0]   in_z_i,
  input  logic [COORD_W-1:0]   in_t_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [INDEX_W-1:0]   out_index_o,
  output logic [COORD_W-1:0]   out_x_o,
  output logic [COORD_W-1:0]   out_y_o,
  output logic [COORD_W-1:0]   out_z_o,
  output logic [COORD_W-1:0]   out_t_o,
  output logic                 range_error_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned EW    = $clog2(MAX_EXTENT + 1);
  localparam int unsigned CW    = $clog2(MAX_EXTENT);
  localparam int unsigned IW    = INDEX_W + 1;
  localparam int unsigned W3    = 4 * EW + 1;
  localparam int unsigned DW0   = 3 * EW + CW + 1;
  localparam int unsigned DW    = (DW0 > IW) ? DW0 : IW;
  localparam int unsigned CMPW  = IW + 4 * EW;
  localparam int unsigned NDIV  = 3 * CW + 1;
  localparam int unsigned S_STP = NDIV + 1;
  localparam int unsigned S_CRY = NDIV + 2;
  localparam int unsigned S_J1  = NDIV + 3;
  localparam int unsigned S_J2  = NDIV + 4;
  localparam int unsigned NST   = NDIV + 6;
  localparam int unsigned LAST  = NST - 1;

  typedef struct packed {
    func_e           func;
    logic [2:0]      dir;
    logic            err;
    logic            divf;
    logic            par;
    logic [IW-1:0]   rem;
    logic [CW:0]     x;
    logic [CW-1:0]   y;
    logic [CW-1:0]   z;
    logic [CW-1:0]   t;
    logic [W3-1:0]   p;
  } pipe_t;

  function automatic logic [EW-1:0] eff_ext(input logic [CFG_W-1:0] r);
    if (r == '0) begin
      eff_ext = EW'(1);
    end else if (32'(r) > MAX_EXTENT) begin
      eff_ext = EW'(MAX_EXTENT);
    end else begin
      eff_ext = EW'(r);
    end
  endfunction

  function automatic logic [CW:0] nb(input logic [CW:0] v, input logic [EW-1:0] l,
                                     input logic back);
    logic [EW+1:0] ve;
    logic [EW+1:0] le;
    ve = (EW+2)'(v);
    le = (EW+2)'(l);
    if (back) begin
      nb = (v == '0) ? (CW+1)'(l - EW'(1)) : v - (CW+1)'(1);
    end else begin
      nb = (ve + (EW+2)'(1) >= le) ? '0 : v + (CW+1)'(1);
    end
  endfunction

  logic [CFG_W-1:0] ext_x_q, ext_y_q, ext_z_q, ext_t_q;
  logic [EW-1:0]    lx, ly, lz, lt;
  logic [2*EW-1:0]  yz_q;
  logic [3*EW-1:0]  yzt_q;
  logic [4*EW-1:0]  vol_q;
  logic [1:0]       settle_q;

  pipe_t            pipe_q [NST];
  pipe_t            pipe_d [NST];
  logic [NST-1:0]   vld_q;
  logic             en;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign lx = eff_ext(ext_x_q);
  assign ly = eff_ext(ext_y_q);
  assign lz = eff_ext(ext_z_q);
  assign lt = eff_ext(ext_t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_x_q  <= CFG_W'(16);
      ext_y_q  <= CFG_W'(16);
      ext_z_q  <= CFG_W'(16);
      ext_t_q  <= CFG_W'(16);
      settle_q <= 2'd3;
    end else if (cfg_valid_i) begin
      settle_q <= 2'd3;
      unique case (cfg_index_i)
        CFG_EXTENT_X: ext_x_q <= cfg_data_i;
        CFG_EXTENT_Y: ext_y_q <= cfg_data_i;
        CFG_EXTENT_Z: ext_z_q <= cfg_data_i;
        CFG_EXTENT_T: ext_t_q <= cfg_data_i;
        default: ;
      endcase
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    yz_q  <= (2*EW)'(ly) * (2*EW)'(lz);
    yzt_q <= (3*EW)'(yz_q) * (3*EW)'(lt);
    vol_q <= (4*EW)'(yzt_q) * (4*EW)'(lx);
  end

  assign en         = !(vld_q[LAST] && out_stall_i);
  assign in_stall_o = !en || (settle_q != 2'd0);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pipe_t          c;
    func_e          fn;
    logic [IW-1:0]  g;
    logic [DW-1:0]  dv;
    logic [DW-1:0]  sh;
    logic           bk;
    logic           cr;
    logic [CW:0]    nv;
    int             k;

    fn     = func_e'(func_i);
    c      = '0;
    c.func = fn;
    c.dir  = direction_i;
    g      = {1'b0, site_index_i};
    if (fn == FN_EVEN || fn == FN_ODD) begin
      g = {site_index_i, fn == FN_ODD};
    end
    c.rem = g;
    if (fn == FN_CRD_TO_IDX || fn == FN_NBR_FWD_CRD || fn == FN_NBR_BWD_CRD) begin
      c.divf = 1'b0;
      c.err  = ((EW+COORD_W)'(in_x_i) >= (EW+COORD_W)'(lx)) ||
               ((EW+COORD_W)'(in_y_i) >= (EW+COORD_W)'(ly)) ||
               ((EW+COORD_W)'(in_z_i) >= (EW+COORD_W)'(lz)) ||
               ((EW+COORD_W)'(in_t_i) >= (EW+COORD_W)'(lt));
      c.x = (CW+1)'(in_x_i);
      c.y = CW'(in_y_i);
      c.z = CW'(in_z_i);
      c.t = CW'(in_t_i);
    end else begin
      c.divf = 1'b1;
      c.err  = CMPW'(g) >= CMPW'(vol_q);
    end
    pipe_d[0] = c;

    for (int s = 1; s < NST; s++) begin
      c  = pipe_q[s-1];
      dv = '0;
      sh = '0;
      k  = 0;
      bk = 1'b0;
      cr = 1'b0;
      nv = '0;
      if (s <= NDIV) begin
        if (s <= CW + 1) begin
          dv = DW'(yzt_q);
          k  = CW + 1 - s;
        end else if (s <= 2 * CW + 1) begin
          dv = DW'(yz_q);
          k  = 2 * CW + 1 - s;
        end else begin
          dv = DW'(ly);
          k  = 3 * CW + 1 - s;
        end
        sh = dv << k;
        if (c.divf && DW'(c.rem) >= sh) begin
          c.rem = IW'(DW'(c.rem) - sh);
          if (s <= CW + 1) begin
            c.x = c.x | ((CW+1)'(1) << k);
          end else if (s <= 2 * CW + 1) begin
            c.t = c.t | (CW'(1) << k);
          end else begin
            c.z = c.z | (CW'(1) << k);
          end
        end
      end else if (s == S_STP) begin
        if (c.divf) begin
          c.y = c.rem[CW-1:0];
        end
        c.par = c.x[0] ^ c.y[0] ^ c.z[0] ^ c.t[0];
        bk = (c.func == FN_NBR_BWD_IDX) || (c.func == FN_NBR_BWD_CRD);
        if (c.func == FN_NBR_FWD_IDX || c.func == FN_NBR_BWD_IDX ||
            c.func == FN_NBR_FWD_CRD || c.func == FN_NBR_BWD_CRD) begin
          unique case (c.dir)
            DIR_X: c.x = nb(c.x, lx, bk);
            DIR_Y: c.y = CW'(nb((CW+1)'(c.y), ly, bk));
            DIR_Z: c.z = CW'(nb((CW+1)'(c.z), lz, bk));
            DIR_T: c.t = CW'(nb((CW+1)'(c.t), lt, bk));
            default: ;
          endcase
        end
      end else if (s == S_CRY) begin
        bk = (c.func == FN_ODD);
        cr = ((c.func == FN_EVEN) && c.par) || ((c.func == FN_ODD) && !c.par);
        if (cr) begin
          nv  = nb((CW+1)'(c.y), ly, bk);
          cr  = bk ? (c.y == '0) : (nv == '0);
          c.y = CW'(nv);
        end
        if (cr) begin
          nv  = nb((CW+1)'(c.z), lz, bk);
          cr  = bk ? (c.z == '0) : (nv == '0);
          c.z = CW'(nv);
        end
        if (cr) begin
          nv  = nb((CW+1)'(c.t), lt, bk);
          cr  = bk ? (c.t == '0) : (nv == '0);
          c.t = CW'(nv);
        end
        if (cr) begin
          c.x = bk ? c.x - (CW+1)'(1) : c.x + (CW+1)'(1);
        end
      end else if (s == S_J1) begin
        c.p = W3'(c.t) + W3'(lt) * W3'(c.x);
      end else if (s == S_J2) begin
        c.p = W3'(c.z) + W3'(lz) * c.p;
      end else begin
        c.p = W3'(c.y) + W3'(ly) * c.p;
        if (c.err) begin
          c.p = '0;
          c.x = '0;
          c.y = '0;
          c.z = '0;
          c.t = '0;
        end
      end
      pipe_d[s] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  assign out_valid_o   = vld_q[LAST];
  assign out_index_o   = INDEX_W'(pipe_q[LAST].p);
  assign out_x_o       = COORD_W'(pipe_q[LAST].x);
  assign out_y_o       = COORD_W'(pipe_q[LAST].y);
  assign out_z_o       = COORD_W'(pipe_q[LAST].z);
  assign out_t_o       = COORD_W'(pipe_q[LAST].t);
  assign range_error_o = pipe_q[LAST].err;

  a_no_accept_settling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q != 2'd0) |-> !accept)
    else $error("item accepted while extent products settle");

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> in_stall_o)
    else $error("request side open right after configuration write");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (out_index_o == '0 && out_x_o == '0 &&
      out_y_o == '0 && out_z_o == '0 && out_t_o == '0))
    else $error("range error result carries nonzero site");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q))
    else $error("pipeline moved under output stall");

endmodule
